@@ hw/rtl/stsm_pkg.sv @@
// Shared types, codes and defaults for the state/timestamp sync matcher.
package stsm_pkg;

	// Default sizes, handed to the top level parameters
	localparam int TABLE_DEPTH_DEF = 64;
	localparam int TIME_WIDTH_DEF  = 48;

	// Fixed field widths
	localparam int KEY_W = 32;
	localparam int OPC_W = 2;

	// Request queue between front and back; a power of two so pointers wrap
	localparam int QUEUE_DEPTH = 2;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER = 1'b1;

	// Reset values of the offset bounds, signed nanoseconds
	localparam int LOWER_RST = -50000000;
	localparam int UPPER_RST = 50000000;

	// Opcode field encodings
	localparam logic [OPC_W-1:0] OPC_CLEAR  = 2'd0;
	localparam logic [OPC_W-1:0] OPC_APPEND = 2'd1;
	localparam logic [OPC_W-1:0] OPC_QUERY  = 2'd2;

	// Classified request kind
	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_APPEND,
		OP_QUERY,
		OP_INVALID
	} op_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_DROPPED  = 3'd0,
		ST_CACHED   = 3'd1,
		ST_SYNC_I   = 3'd2,
		ST_SYNC_J   = 3'd3,
		ST_INTERP   = 3'd4,
		ST_ACCEPTED = 3'd5,
		ST_REJECTED = 3'd6
	} status_t;

	// Result tag, carried on the output user sideband (status lowest)
	typedef struct packed {
		logic    found;
		status_t status;
	} res_tag_t;

	// Back-end sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_PRE,
		S_SADDR,
		S_SCMP,
		S_PRV,
		S_RDA,
		S_RDB,
		S_CAPB,
		S_DIFF,
		S_CHK,
		S_FIN
	} state_t;

endpackage

@@ hw/rtl/stsm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module stsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port, then registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/stsm_front.sv @@
// Front end: accepts input requests, classifies the opcode and queues them.
module stsm_front import stsm_pkg::*; #(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_valid,
	output logic                  s_ready,
	input  logic [OPC_W-1:0]      s_opcode,
	input  logic [KEY_W-1:0]      s_key,
	input  logic [TIME_WIDTH-1:0] s_time,
	output logic                  q_valid,
	output op_t                   q_op,
	output logic [KEY_W-1:0]      q_key,
	output logic [TIME_WIDTH-1:0] q_time,
	input  logic                  q_pop
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int LW = $clog2(QUEUE_DEPTH + 1);

	op_t                   op_mem  [QUEUE_DEPTH];
	logic [KEY_W-1:0]      key_mem [QUEUE_DEPTH];
	logic [TIME_WIDTH-1:0] time_mem[QUEUE_DEPTH];

	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [LW-1:0] level_q;
	op_t           op_c;
	logic          push;

	// Classify the opcode
	always_comb begin
		unique case (s_opcode)
			OPC_CLEAR:  op_c = OP_CLEAR;
			OPC_APPEND: op_c = OP_APPEND;
			OPC_QUERY:  op_c = OP_QUERY;
			default:    op_c = OP_INVALID;
		endcase
	end

	assign s_ready = (level_q != LW'(QUEUE_DEPTH));
	assign push    = s_valid && s_ready;
	assign q_valid = (level_q != '0);
	assign q_op    = op_mem[rd_ptr_q];
	assign q_key   = key_mem[rd_ptr_q];
	assign q_time  = time_mem[rd_ptr_q];

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !q_pop) begin
				level_q <= level_q + LW'(1);
			end else if (!push && q_pop) begin
				level_q <= level_q - LW'(1);
			end
		end
	end

	// Hold queued request payloads
	always_ff @(posedge clk) begin
		if (push) begin
			op_mem[wr_ptr_q]   <= op_c;
			key_mem[wr_ptr_q]  <= s_key;
			time_mem[wr_ptr_q] <= s_time;
		end
	end

endmodule

@@ hw/rtl/stsm_back.sv @@
// Back end: table storage, binary search, candidate selection and result register.
module stsm_back import stsm_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  op_t                          q_op,
	input  logic [KEY_W-1:0]             q_key,
	input  logic [TIME_WIDTH-1:0]        q_time,
	output logic                         q_pop,
	input  logic signed [TIME_WIDTH-1:0] lower_bound,
	input  logic signed [TIME_WIDTH-1:0] upper_bound,
	output logic                         out_valid,
	input  logic                         out_ready,
	output res_tag_t                     out_tag,
	output logic [KEY_W-1:0]             out_key_i,
	output logic [KEY_W-1:0]             out_key_j,
	output logic [TIME_WIDTH-1:0]        out_time_i,
	output logic [TIME_WIDTH-1:0]        out_time_j,
	output logic [TIME_WIDTH-1:0]        out_dur
);

	localparam int TW = TIME_WIDTH;
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int WW = KEY_W + TW;

	state_t state_q, state_d;

	// Table bookkeeping
	logic [CW-1:0] count_q;
	logic [TW-1:0] first_q, last_q;

	// Query working registers
	logic [TW-1:0]        m_q;
	logic [CW-1:0]        lo_q, hi_q, nxt_q;
	logic [AW-1:0]        prv_q, pb_addr_q;
	logic                 b_exists_q, pair_q;
	logic [KEY_W-1:0]     ka_q, kb_q;
	logic [TW-1:0]        ta_q, tb_q;
	logic signed [TW:0]   di_q, dj_q;
	logic                 vi_q, vj_q;
	logic [TW:0]          magi_q, magj_q;

	// Result register
	logic                 out_valid_q;
	res_tag_t             out_tag_q;
	logic [KEY_W-1:0]     out_key_i_q, out_key_j_q;
	logic [TW-1:0]        out_time_i_q, out_time_j_q, out_dur_q;

	// RAM port signals
	logic                 ram_we;
	logic [AW-1:0]        ram_raddr;
	logic [WW-1:0]        ram_rdata;
	logic [KEY_W-1:0]     rd_key;
	logic [TW-1:0]        rd_time;

	// Combinational helpers
	logic                 out_free;
	logic                 append_ok;
	logic                 pre_drop, pre_cache;
	logic signed [TW:0]   d_last;
	logic signed [TW:0]   lower_x, upper_x;
	logic [CW:0]          mid_sum;
	logic [AW-1:0]        mid;
	logic                 scmp_less;
	logic [CW-1:0]        lo_n, hi_n;
	logic                 nxt_exists;
	logic [CW-1:0]        prv_c, pb_c;
	logic                 sel_j;
	logic signed [TW:0]   di_c, dj_c;

	// Result being loaded
	logic                 res_load;
	res_tag_t             res_tag;
	logic [KEY_W-1:0]     res_key_i, res_key_j;
	logic [TW-1:0]        res_time_i, res_time_j, res_dur;

	stsm_ram #(
		.WIDTH (WW),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata ({q_key, q_time}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_key  = ram_rdata[WW-1:TW];
	assign rd_time = ram_rdata[TW-1:0];

	assign out_free = !out_valid_q || out_ready;
	assign lower_x  = {lower_bound[TW-1], lower_bound};
	assign upper_x  = {upper_bound[TW-1], upper_bound};

	// Append admission: room left and strictly later than the last entry
	assign append_ok = (count_q < CW'(TABLE_DEPTH)) && ((count_q == '0) || (q_time > last_q));

	// Early query outcomes
	assign d_last    = {1'b0, m_q} - {1'b0, last_q};
	assign pre_drop  = (count_q == '0) || (m_q < first_q);
	assign pre_cache = (d_last > upper_x);

	// Binary search step: find the first entry not earlier than the measurement
	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid       = mid_sum[AW:1];
	assign scmp_less = (rd_time < m_q);
	assign lo_n      = scmp_less ? (CW'(mid) + CW'(1)) : lo_q;
	assign hi_n      = scmp_less ? hi_q : CW'(mid);

	// Bracketing pair from the search result
	assign nxt_exists = (nxt_q < count_q);
	always_comb begin
		if (!nxt_exists) begin
			prv_c = count_q - CW'(1);
		end else if (nxt_q != '0) begin
			prv_c = nxt_q - CW'(1);
		end else begin
			prv_c = '0;
		end
	end
	assign pb_c = prv_c + CW'(1);

	// Offsets from both bracketing states
	assign di_c = {1'b0, m_q} - {1'b0, ta_q};
	assign dj_c = {1'b0, m_q} - {1'b0, tb_q};

	// Prefer the later state only when strictly nearer, or the earlier is out of bounds
	assign sel_j = vj_q && (!vi_q || (magj_q < magi_q));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (q_valid && (q_op == OP_QUERY)) begin
					state_d = S_PRE;
				end
			end
			S_PRE: begin
				if (pre_drop || pre_cache) begin
					if (out_free) begin
						state_d = S_IDLE;
					end
				end else begin
					state_d = S_SADDR;
				end
			end
			S_SADDR: state_d = S_SCMP;
			S_SCMP:  state_d = (lo_n == hi_n) ? S_PRV : S_SADDR;
			S_PRV:   state_d = S_RDA;
			S_RDA:   state_d = S_RDB;
			S_RDB:   state_d = S_CAPB;
			S_CAPB:  state_d = S_DIFF;
			S_DIFF:  state_d = S_CHK;
			S_CHK:   state_d = S_FIN;
			S_FIN: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		q_pop      = 1'b0;
		ram_we     = 1'b0;
		ram_raddr  = mid;
		res_load   = 1'b0;
		res_tag    = '{found: 1'b0, status: ST_DROPPED};
		res_key_i  = '0;
		res_key_j  = '0;
		res_time_i = '0;
		res_time_j = '0;
		res_dur    = '0;
		unique case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					if (q_op == OP_QUERY) begin
						q_pop = 1'b1;
					end else if (out_free) begin
						q_pop    = 1'b1;
						res_load = 1'b1;
						case (q_op)
							OP_CLEAR: res_tag.status = ST_ACCEPTED;
							OP_APPEND: begin
								ram_we         = append_ok;
								res_tag.status = append_ok ? ST_ACCEPTED : ST_REJECTED;
							end
							default: res_tag.status = ST_REJECTED;
						endcase
					end
				end
			end
			S_PRE: begin
				if ((pre_drop || pre_cache) && out_free) begin
					res_load       = 1'b1;
					res_tag.status = pre_drop ? ST_DROPPED : ST_CACHED;
				end
			end
			S_RDA: ram_raddr = prv_q;
			S_RDB: ram_raddr = pb_addr_q;
			S_FIN: begin
				if (out_free) begin
					res_load = 1'b1;
					if (sel_j) begin
						res_tag = '{found: 1'b1, status: ST_SYNC_J};
					end else if (vi_q) begin
						res_tag = '{found: 1'b1, status: ST_SYNC_I};
					end else if (pair_q) begin
						res_tag = '{found: 1'b1, status: ST_INTERP};
					end
					if (sel_j || vi_q || pair_q) begin
						res_key_i  = ka_q;
						res_time_i = ta_q;
						res_key_j  = b_exists_q ? kb_q : ka_q;
						res_time_j = b_exists_q ? tb_q : ta_q;
						res_dur    = (!di_q[TW] && (di_q != '0)) ? di_q[TW-1:0] : '0;
					end
				end
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && q_pop) begin
				if (q_op == OP_CLEAR) begin
					count_q <= '0;
				end else if (q_op == OP_APPEND && append_ok) begin
					count_q <= count_q + CW'(1);
				end
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && q_pop) begin
			m_q <= q_time;
			if (q_op == OP_APPEND && append_ok) begin
				last_q <= q_time;
				if (count_q == '0) begin
					first_q <= q_time;
				end
			end
		end
		if (state_q == S_PRE) begin
			lo_q <= '0;
			hi_q <= count_q;
		end
		if (state_q == S_SCMP) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			nxt_q <= lo_n;
		end
		if (state_q == S_PRV) begin
			prv_q      <= prv_c[AW-1:0];
			pb_addr_q  <= pb_c[AW-1:0];
			b_exists_q <= (pb_c < count_q);
			pair_q     <= nxt_exists && (nxt_q != '0);
		end
		if (state_q == S_RDB) begin
			ka_q <= rd_key;
			ta_q <= rd_time;
		end
		if (state_q == S_CAPB) begin
			kb_q <= rd_key;
			tb_q <= rd_time;
		end
		if (state_q == S_DIFF) begin
			di_q <= di_c;
			dj_q <= dj_c;
		end
		if (state_q == S_CHK) begin
			vi_q   <= (di_q >= lower_x) && (di_q <= upper_x);
			vj_q   <= pair_q && (dj_q >= lower_x) && (dj_q <= upper_x);
			magi_q <= di_q[TW] ? -di_q : di_q;
			magj_q <= dj_q[TW] ? -dj_q : dj_q;
		end
		if (res_load) begin
			out_tag_q    <= res_tag;
			out_key_i_q  <= res_key_i;
			out_key_j_q  <= res_key_j;
			out_time_i_q <= res_time_i;
			out_time_j_q <= res_time_j;
			out_dur_q    <= res_dur;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_tag    = out_tag_q;
	assign out_key_i  = out_key_i_q;
	assign out_key_j  = out_key_j_q;
	assign out_time_i = out_time_i_q;
	assign out_time_j = out_time_j_q;
	assign out_dur    = out_dur_q;

endmodule

@@ hw/rtl/state_timestamp_sync_matcher.sv @@
// Top level of the state/timestamp sync matcher: ports, bound registers and wiring.
//
// Keeps up to TABLE_DEPTH (state key, timestamp) entries in time order in one
// RAM and answers one result per request. Requests enter a two-deep queue, so
// the input side keeps accepting, until the queue is full, while the back end
// works or the result register waits. A clear or append is handled in S_IDLE.
// A query steps through S_PRE, then binary search steps of S_SADDR and S_SCMP
// around the registered read of the single table RAM port; S_RDA and S_RDB
// read the bracketing pair, and S_CAPB, S_DIFF, S_CHK and S_FIN compute
// offsets, bound checks and the choice. A dropped or cached query ends in S_PRE.
// Bounds are written by index (0 lower, 1 upper) while the block is idle; the
// user must keep to this, as the block itself does not enforce it.
module state_timestamp_sync_matcher import stsm_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Input requests
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// s_tdata fields from bit 0: state_key, time_value, zero padding
	input  logic [((KEY_W + TIME_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
	// s_tuser fields from bit 0: opcode
	input  logic [OPC_W-1:0]       s_tuser,
	// Results
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// m_tdata fields from bit 0: key_i, key_j, time_i, time_j, duration_from_i, zero padding
	output logic [((2 * KEY_W + 3 * TIME_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
	// m_tuser fields from bit 0: status, found
	output logic [$bits(res_tag_t)-1:0] m_tuser,
	// Configuration writes
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [TIME_WIDTH-1:0]  cfg_wdata
);

	localparam int OUT_W = ((2 * KEY_W + 3 * TIME_WIDTH + 7) / 8) * 8;

	logic signed [TIME_WIDTH-1:0] lower_q, upper_q;

	logic                  q_valid, q_pop;
	op_t                   q_op;
	logic [KEY_W-1:0]      q_key;
	logic [TIME_WIDTH-1:0] q_time;

	res_tag_t              out_tag;
	logic [KEY_W-1:0]      out_key_i, out_key_j;
	logic [TIME_WIDTH-1:0] out_time_i, out_time_j, out_dur;

	// Hold the offset bound registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= TIME_WIDTH'(LOWER_RST);
			upper_q <= TIME_WIDTH'(UPPER_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOWER: lower_q <= cfg_wdata;
				REG_UPPER: upper_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	stsm_front #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_valid  (s_tvalid),
		.s_ready  (s_tready),
		.s_opcode (s_tuser),
		.s_key    (s_tdata[KEY_W-1:0]),
		.s_time   (s_tdata[KEY_W+TIME_WIDTH-1:KEY_W]),
		.q_valid  (q_valid),
		.q_op     (q_op),
		.q_key    (q_key),
		.q_time   (q_time),
		.q_pop    (q_pop)
	);

	stsm_back #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.TIME_WIDTH  (TIME_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_op        (q_op),
		.q_key       (q_key),
		.q_time      (q_time),
		.q_pop       (q_pop),
		.lower_bound (lower_q),
		.upper_bound (upper_q),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_tag     (out_tag),
		.out_key_i   (out_key_i),
		.out_key_j   (out_key_j),
		.out_time_i  (out_time_i),
		.out_time_j  (out_time_j),
		.out_dur     (out_dur)
	);

	// Pack the result fields
	assign m_tdata = OUT_W'({out_dur, out_time_j, out_time_i, out_key_j, out_key_i});
	assign m_tuser = out_tag;

endmodule

@@ sim/tb_state_timestamp_sync_matcher.sv @@
// Self-checking bench for the state/timestamp sync matcher: table upkeep, queries, bounds, flow control.
`timescale 1ns / 100ps

module tb_state_timestamp_sync_matcher;
	import stsm_pkg::*;

	localparam int TW       = TIME_WIDTH_DEF;
	localparam int DEPTH    = TABLE_DEPTH_DEF;
	localparam int S_DATA_W = ((KEY_W + TW + 7) / 8) * 8;
	localparam int M_DATA_W = ((2 * KEY_W + 3 * TW + 7) / 8) * 8;

	// Opcode the block does not define; it must be rejected
	localparam logic [OPC_W-1:0] OPC_UNUSED = 2'd3;

	localparam logic [TW-1:0] TIME_MAX  = '1;
	localparam longint        BOUND_MAX = (longint'(1) << (TW - 1)) - 1;
	localparam longint        BOUND_MIN = -BOUND_MAX - 1;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 64;
	localparam int MAX_REPORTS  = 10;
	localparam int HOLD_CYCLES  = 400;

	// One expected result, fields at block widths
	typedef struct packed {
		status_t         status;
		logic            found;
		logic [KEY_W-1:0] key_i;
		logic [KEY_W-1:0] key_j;
		logic [TW-1:0]   time_i;
		logic [TW-1:0]   time_j;
		logic [TW-1:0]   dur;
	} sync_result_t;

	// Association of a measurement with one bracketing state
	typedef struct {
		logic             valid;
		longint           mag;
		logic [KEY_W-1:0] key_i;
		logic [KEY_W-1:0] key_j;
		logic [TW-1:0]    time_i;
		logic [TW-1:0]    time_j;
		logic [TW-1:0]    dur;
	} pairing_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata   = '0;
	logic [OPC_W-1:0]      s_tuser   = OPC_CLEAR;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;
	logic [$bits(res_tag_t)-1:0] m_tuser;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_LOWER;
	logic [TW-1:0]         cfg_wdata = '0;

	// Shadow of the table and the bound registers
	logic [KEY_W-1:0] key_table [DEPTH];
	logic [TW-1:0]    time_table [DEPTH];
	int               table_count = 0;
	longint           lower_bound = LOWER_RST;
	longint           upper_bound = UPPER_RST;

	sync_result_t expected_sync_results [$];
	int           mismatch_count = 0;
	int           cycle_count = 0;
	int           sender_idle_pct = 19;
	int           receiver_idle_pct = 80;
	int           receiver_hold_len = 0;
	int           hold_count = 0;
	logic         hold_taken = 1'b0;

	state_timestamp_sync_matcher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	// Abort a run that hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver: random back-pressure, plus one long hold when asked
	always @(posedge clk) begin
		if (receiver_hold_len != 0 && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_count <= receiver_hold_len;
			m_tready <= 1'b0;
		end else if (hold_count > 0) begin
			hold_count <= hold_count - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
		end
	end

	function automatic logic [TW-1:0] random_time();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[TW-1:0];
	endfunction

	// Try to associate measurement m with the state at idx, as state i or as state j
	function automatic pairing_t pair_with(int idx, bit as_i, logic [TW-1:0] m);
		pairing_t p;
		longint   d;
		longint   di;
		p = '{default: 0};
		d = longint'(m) - longint'(time_table[idx]);
		if (d < lower_bound || d > upper_bound)
			return p;
		p.valid = 1'b1;
		p.mag = (d < 0) ? -d : d;
		if (as_i) begin
			p.key_i = key_table[idx];
			p.time_i = time_table[idx];
			p.dur = (d > 0) ? d[TW-1:0] : '0;
			// the last state pairs with itself
			if (idx + 1 < table_count) begin
				p.key_j = key_table[idx + 1];
				p.time_j = time_table[idx + 1];
			end else begin
				p.key_j = p.key_i;
				p.time_j = p.time_i;
			end
		end else begin
			if (idx == 0) begin
				p.valid = 1'b0;
				return p;
			end
			p.key_j = key_table[idx];
			p.time_j = time_table[idx];
			p.key_i = key_table[idx - 1];
			p.time_i = time_table[idx - 1];
			di = longint'(m) - longint'(p.time_i);
			p.dur = (di > 0) ? di[TW-1:0] : '0;
		end
		return p;
	endfunction

	function automatic sync_result_t resolve_query(logic [TW-1:0] m);
		sync_result_t r;
		pairing_t     best;
		pairing_t     later;
		int           last;
		int           nxt;
		int           prv;
		bit           next_exists;
		bit           prev_exists;
		bit           to_j;
		r = '0;
		r.status = ST_DROPPED;
		to_j = 1'b0;
		if (table_count == 0 || m < time_table[0])
			return r;
		last = table_count - 1;
		if (longint'(m) - longint'(time_table[last]) > upper_bound) begin
			r.status = ST_CACHED;
			return r;
		end
		// find the first state not earlier than m
		nxt = 0;
		while (nxt < table_count && time_table[nxt] < m)
			nxt++;
		next_exists = (nxt < table_count);
		prev_exists = next_exists ? (nxt != 0) : 1'b1;
		prv = next_exists ? (prev_exists ? nxt - 1 : nxt) : last;
		best = pair_with(prv, 1'b1, m);
		if (next_exists) begin
			later = pair_with(nxt, 1'b0, m);
			// a tie stays with the earlier state
			if (later.valid && (!best.valid || later.mag < best.mag)) begin
				best = later;
				to_j = 1'b1;
			end
		end
		if (best.valid) begin
			r.status = to_j ? ST_SYNC_J : ST_SYNC_I;
			r.found = 1'b1;
			r.key_i = best.key_i;
			r.key_j = best.key_j;
			r.time_i = best.time_i;
			r.time_j = best.time_j;
			r.dur = best.dur;
		end else if (prev_exists && next_exists) begin
			r.status = ST_INTERP;
			r.found = 1'b1;
			r.key_i = key_table[prv];
			r.key_j = key_table[nxt];
			r.time_i = time_table[prv];
			r.time_j = time_table[nxt];
			r.dur = m - time_table[prv];
		end
		return r;
	endfunction

	// Apply one request to the shadow table and return its result
	function automatic sync_result_t predict_sync_result(logic [OPC_W-1:0] op,
			logic [KEY_W-1:0] key, logic [TW-1:0] t);
		sync_result_t r;
		r = '0;
		case (op)
		OPC_CLEAR: begin
			table_count = 0;
			r.status = ST_ACCEPTED;
		end
		OPC_APPEND: begin
			if (table_count >= DEPTH ||
					(table_count > 0 && t <= time_table[table_count - 1])) begin
				r.status = ST_REJECTED;
			end else begin
				key_table[table_count] = key;
				time_table[table_count] = t;
				table_count++;
				r.status = ST_ACCEPTED;
			end
		end
		OPC_QUERY: begin
			r = resolve_query(t);
		end
		default: begin
			r.status = ST_REJECTED;
		end
		endcase
		return r;
	endfunction

	task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("%0t: %s expected %0h got %0h", $time, field, want, got);
		end
	endtask

	// Compare each result with the oldest expectation
	always @(posedge clk) begin
		sync_result_t want;
		res_tag_t     tag;
		if (arst_n && m_tvalid && m_tready) begin
			tag = res_tag_t'(m_tuser);
			if (expected_sync_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: result with nothing expected, status %0d", $time, tag.status);
			end else begin
				want = expected_sync_results.pop_front();
				check_field("status", want.status, tag.status);
				check_field("found", want.found, tag.found);
				check_field("key_i", want.key_i, m_tdata[KEY_W-1:0]);
				check_field("key_j", want.key_j, m_tdata[2*KEY_W-1:KEY_W]);
				check_field("time_i", want.time_i, m_tdata[2*KEY_W +: TW]);
				check_field("time_j", want.time_j, m_tdata[2*KEY_W+TW +: TW]);
				check_field("duration_from_i", want.dur, m_tdata[2*KEY_W+2*TW +: TW]);
			end
		end
	end

	// Offer one request, idling first at random; hold valid high across back-to-back requests
	task automatic send_request(logic [OPC_W-1:0] op, logic [KEY_W-1:0] key, logic [TW-1:0] t);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= S_DATA_W'({t, key});
		do @(posedge clk); while (s_tready !== 1'b1);
		expected_sync_results.insert(expected_sync_results.size(),
			predict_sync_result(op, key, t));
	endtask

	// Drop valid and wait until every result is back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_sync_results.size() != 0);
	endtask

	task automatic set_bounds(longint lower, longint upper);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= REG_LOWER;
		cfg_wdata <= lower[TW-1:0];
		@(posedge clk);
		cfg_index <= REG_UPPER;
		cfg_wdata <= upper[TW-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		lower_bound = longint'(signed'(lower[TW-1:0]));
		upper_bound = longint'(signed'(upper[TW-1:0]));
	endtask

	function automatic longint pick_spacing();
		case ($urandom_range(0, 4))
		0: return longint'($urandom_range(1, 64));
		1: return longint'($urandom_range(10_000_000, 40_000_000));
		2: return longint'($urandom_range(40_000_000, 150_000_000));
		3: return longint'($urandom_range(1, 1000)) << 20;
		default: return longint'($urandom) << $urandom_range(0, 8);
		endcase
	endfunction

	// Query near a stored state or at a random time: exact hits, midpoints, small offsets, past the end
	task automatic send_near_query(longint spacing);
		longint probe;
		int     k;
		int     pick;
		pick = $urandom_range(0, 9);
		if (table_count == 0 || pick == 0) begin
			probe = longint'(random_time());
		end else begin
			k = $urandom_range(0, table_count - 1);
			probe = longint'(time_table[k]);
			case (pick)
			1: probe = longint'(time_table[table_count - 1]) +
					longint'($urandom_range(0, 2048)) * spacing / 512;
			2: if (k + 1 < table_count)
					probe += (longint'(time_table[k + 1]) - longint'(time_table[k])) / 2;
			3: begin
				// exact hit on a state
			end
			default: probe += (longint'($urandom_range(0, 2048)) - 1024) * spacing / 512;
			endcase
		end
		send_request(OPC_QUERY, $urandom, probe[TW-1:0]);
	endtask

	// Clear, build an increasing timeline with a few bad appends, then query it amid random requests
	task automatic run_timeline(int n_entries, int n_queries, longint spacing);
		longint next_t;
		int     n;
		send_request(OPC_CLEAR, $urandom, random_time());
		next_t = longint'(random_time() >> $urandom_range(0, 3));
		for (n = 0; n < n_entries; n++) begin
			if (table_count > 0 && $urandom_range(0, 19) == 0) begin
				// repeat or step back in time
				send_request(OPC_APPEND, $urandom,
					time_table[table_count - 1] - TW'($urandom_range(0, 3)));
			end else begin
				next_t += 1 + longint'($urandom_range(0, 1023)) * spacing / 512;
				send_request(OPC_APPEND, $urandom, next_t[TW-1:0]);
			end
		end
		for (n = 0; n < n_queries; n++) begin
			if ($urandom_range(0, 11) == 0)
				send_request(OPC_W'($urandom_range(0, 3)), $urandom, random_time());
			else
				send_near_query(spacing);
		end
	endtask

	task automatic test_random_timelines(int count);
		repeat (count)
			run_timeline($urandom_range(1, 12), $urandom_range(4, 12), pick_spacing());
	endtask

	// Edges of the fields and each named case, under the reset bounds
	task automatic test_directed();
		send_request(OPC_QUERY, 32'h0000_0000, 48'd1000);             // empty table
		send_request(OPC_APPEND, 32'hFFFF_FFFF, 48'd0);               // earliest time
		send_request(OPC_APPEND, 32'h0000_0001, 48'd0);               // same time again
		send_request(OPC_APPEND, 32'h0000_0000, 48'd1_000_000);
		send_request(OPC_APPEND, 32'h0000_0002, 48'd500);             // back in time
		send_request(OPC_QUERY, 32'hFFFF_FFFF, 48'd0);                // exact hit on first
		send_request(OPC_QUERY, 32'h0, 48'd1_000_000);                // exact hit on the last state
		send_request(OPC_QUERY, 32'h0, 48'd51_000_001);               // just past upper bound
		send_request(OPC_QUERY, 32'h0, 48'd51_000_000);               // on the upper bound
		send_request(OPC_APPEND, 32'h1234_5678, 48'd200_000_000);
		send_request(OPC_APPEND, 32'h8765_4321, 48'd200_000_100);
		send_request(OPC_QUERY, 32'h0, 48'd30_000_000);               // near earlier state
		send_request(OPC_QUERY, 32'h0, 48'd199_999_990);              // near later state
		send_request(OPC_QUERY, 32'h0, 48'd100_000_000);              // neither in bounds
		send_request(OPC_QUERY, 32'h0, 48'd200_000_050);              // equal distance
		send_request(OPC_APPEND, 32'hA5A5_A5A5, TIME_MAX);            // latest time
		send_request(OPC_QUERY, 32'hFFFF_FFFF, TIME_MAX);
		send_request(OPC_APPEND, 32'h5A5A_5A5A, TIME_MAX);            // duplicate at the top
		send_request(OPC_UNUSED, 32'hFFFF_FFFF, TIME_MAX);
		send_request(OPC_QUERY, 32'h0, TIME_MAX - 1);
		send_request(OPC_CLEAR, 32'hFFFF_FFFF, TIME_MAX);
		send_request(OPC_QUERY, 32'h0, 48'd0);                        // cleared table
		send_request(OPC_APPEND, 32'h0, 48'd5000);
		send_request(OPC_QUERY, 32'h0, 48'd4999);                     // before first state
	endtask

	// Sweep the bound registers through extremes, narrow, negative and crossed windows
	task automatic test_bound_settings();
		set_bounds(BOUND_MIN, BOUND_MAX);
		test_random_timelines(2);
		set_bounds(0, 0);
		test_random_timelines(2);
		set_bounds(10, 100);
		send_request(OPC_CLEAR, $urandom, random_time());
		send_request(OPC_APPEND, $urandom, 48'd1000);
		send_request(OPC_QUERY, $urandom, 48'd1005);                  // no valid state, no pair
		send_request(OPC_QUERY, $urandom, 48'd1000);
		test_random_timelines(2);
		set_bounds(-100, -10);
		test_random_timelines(2);
		// crossed window: nothing can be in bounds
		set_bounds(100, 10);
		test_random_timelines(2);
		set_bounds(BOUND_MAX, BOUND_MIN);
		test_random_timelines(1);
		set_bounds(LOWER_RST, UPPER_RST);
	endtask

	// Fill the table, overflow it, then query across it
	task automatic test_full_table();
		longint next_t;
		send_request(OPC_CLEAR, $urandom, random_time());
		next_t = longint'($urandom_range(0, 1000));
		repeat (DEPTH + 2) begin
			next_t += 20_000_000 + longint'($urandom_range(0, 999));
			send_request(OPC_APPEND, $urandom, next_t[TW-1:0]);
		end
		repeat (12)
			send_near_query(20_000_000);
		send_request(OPC_APPEND, $urandom, TIME_MAX);
	endtask

	// Hold the receiver off while requests keep coming, so the input side stalls
	task automatic test_backpressure();
		receiver_hold_len = HOLD_CYCLES;
		run_timeline(10, 15, pick_spacing());
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_timelines(5);

		wait_idle();
		sender_idle_pct = 80;
		receiver_idle_pct = 19;
		test_bound_settings();

		wait_idle();
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		test_full_table();
		test_backpressure();
		test_random_timelines(5);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_sync_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/stsm_pkg.sv
hw/rtl/stsm_ram.sv
hw/rtl/stsm_front.sv
hw/rtl/stsm_back.sv
hw/rtl/state_timestamp_sync_matcher.sv
sim/tb_state_timestamp_sync_matcher.sv
